[rtl/iopb_pkg.sv]
// Shared types and constants for the I/O permission bitmap block.
// Depends on nothing; imported by the top level and its checker.
`default_nettype none

package iopb_pkg;

	localparam int WORD_BITS = 32;
	localparam int PORT_W = 16;
	localparam int WIDX_W = 5;
	localparam int WCNT_W = PORT_W - 5;
	localparam int RESERVED_PORTS = 8;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PERM  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		FN_UPDATE = 1'b0,
		FN_READ   = 1'b1
	} func_t;

endpackage

`default_nettype wire

[rtl/io_permission_bitmap_update.sv]
// I/O port permission bitmap: range grant/revoke and single word read.
// Depends on iopb_pkg; bitmap held in an internal single-port style memory.
//
// Usage: one input channel (in_valid/in_stall) carries func, first_port,
// port_count, grant, privileged and word_index. One output channel
// (out_valid/out_stall) returns status and word_data, one result per item.
// A transfer happens on a clock edge with valid high and stall low.
// A bit of 0 allows the port, 1 denies it.
// Flow: a rejected update or an empty range goes from its transfer through
// S_DONE to the output register, a read through S_RDW and S_DONE. An update
// walks the bitmap one word per step through a shared mask unit: a whole
// word is written in S_WALK, a partial end word is read in S_WALK and
// written back in S_MOD (read then write back), then S_DONE loads the output.
// in_stall is high from a transfer until its result is in the output
// register; the next item may be taken while that result waits.
// If out_stall holds a result, a finished item waits and the block stalls.
// Reset: arst_n clears all control state, then a clearing pass writes all
// ones to the bitmap, one word a cycle, while in_stall is high.
`default_nettype none

module io_permission_bitmap_update #(
	parameter int BITMAP_WORDS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic [15:0]                first_port,
	input  wire logic [15:0]                port_count,
	input  wire logic                       grant,
	input  wire logic                       privileged,
	input  wire logic [4:0]                 word_index,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output iopb_pkg::status_t               status,
	output logic [31:0]                     word_data
);
	import iopb_pkg::*;

	localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam logic [PORT_W:0] LIMIT = (PORT_W + 1)'(BITMAP_WORDS * WORD_BITS - RESERVED_PORTS);
	localparam logic [WCNT_W:0] NWORDS = (WCNT_W + 1)'(BITMAP_WORDS);
	localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(BITMAP_WORDS - 1);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_WALK,
		S_MOD,
		S_RDW,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [WCNT_W-1:0]   w_q;
	logic [PORT_W-1:0]   first_q;
	logic [PORT_W-1:0]   last_q;
	logic                grant_q;
	status_t             res_status_q;
	logic [31:0]         res_data_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [31:0]         out_data_q;

	logic [31:0]         mem [BITMAP_WORDS];
	logic [31:0]         rd_data_q;

	logic [PORT_W:0]     end_sum;
	logic                in_xfer;
	logic                out_free;
	logic [4:0]          lo;
	logic [4:0]          hi;
	logic [31:0]         mask;
	logic                full_word;
	logic                last_step;
	logic [WCNT_W-1:0]   idx_ext;
	logic                mem_we;
	logic [WCNT_W-1:0]   mem_wa;
	logic [31:0]         mem_wd;
	logic                mem_re;
	logic [WCNT_W-1:0]   mem_ra;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign end_sum   = {1'b0, first_port} + {1'b0, port_count};
	assign idx_ext   = WCNT_W'(word_index);

	assign lo        = (w_q == first_q[PORT_W-1:5]) ? first_q[4:0] : 5'd0;
	assign hi        = (w_q == last_q[PORT_W-1:5]) ? last_q[4:0] : 5'd31;
	assign mask      = (32'hFFFF_FFFF << lo) & (32'hFFFF_FFFF >> (5'd31 - hi));
	assign full_word = (mask == 32'hFFFF_FFFF);
	assign last_step = (w_q == last_q[PORT_W-1:5]);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = w_q;
		mem_wd = 32'hFFFF_FFFF;
		mem_re = 1'b0;
		mem_ra = w_q;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				mem_re = in_xfer && (func == FN_READ);
				mem_ra = idx_ext;
			end
			S_WALK: begin
				if (full_word) begin
					mem_we = 1'b1;
					mem_wd = grant_q ? 32'h0 : 32'hFFFF_FFFF;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_MOD: begin
				mem_we = 1'b1;
				mem_wd = grant_q ? (rd_data_q & ~mask) : (rd_data_q | mask);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa[AW-1:0]] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			w_q          <= '0;
			first_q      <= '0;
			last_q       <= '0;
			grant_q      <= 1'b0;
			res_status_q <= ST_OK;
			res_data_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_data_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					w_q <= w_q + 1'b1;
					if (w_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						res_data_q <= '0;
						first_q    <= first_port;
						last_q     <= PORT_W'(end_sum - 1'b1);
						grant_q    <= grant;
						w_q        <= first_port[PORT_W-1:5];
						if (func == FN_READ) begin
							if ({1'b0, idx_ext} < NWORDS) begin
								res_status_q <= ST_OK;
								state_q      <= S_RDW;
							end else begin
								res_status_q <= ST_RANGE;
								state_q      <= S_DONE;
							end
						end else if (!privileged) begin
							res_status_q <= ST_PERM;
							state_q      <= S_DONE;
						end else if (end_sum > LIMIT) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= (port_count == '0) ? S_DONE : S_WALK;
						end
					end
				end
				S_WALK: begin
					if (!full_word) begin
						state_q <= S_MOD;
					end else if (last_step) begin
						state_q <= S_DONE;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_MOD: begin
					if (last_step) begin
						state_q <= S_DONE;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_RDW: begin
					res_data_q <= rd_data_q;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= res_data_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign word_data = out_data_q;

endmodule

`default_nettype wire

[rtl/iopb_checker.sv]
// Port-level checks for the I/O permission bitmap block, bound to its top level.
// Depends on iopb_pkg and io_permission_bitmap_update.
`default_nettype none

module iopb_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire iopb_pkg::status_t status,
	input wire logic [31:0]       word_data
);
	import iopb_pkg::*;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	a_reject_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> word_data == 32'h0)
		else $error("rejected item carries data");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && in_stall)
		else $error("activity during reset");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(word_data))
		else $error("stalled result changed");

endmodule

bind io_permission_bitmap_update iopb_checker u_iopb_checker (.*);

`default_nettype wire
